// ===== rtl/ofr_pkg.sv =====
// ofr_pkg: widths and payload types for the orthonormal frame core.
// No dependencies; used by every file under rtl/.
`default_nettype none

package ofr_pkg;

	// input component width and output fraction bits
	localparam int IN_BITS       = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_BITS      = 16;

	typedef struct packed {
		logic signed [IN_BITS-1:0] fiber_x;
		logic signed [IN_BITS-1:0] fiber_y;
		logic signed [IN_BITS-1:0] fiber_z;
		logic signed [IN_BITS-1:0] sheet_x;
		logic signed [IN_BITS-1:0] sheet_y;
		logic signed [IN_BITS-1:0] sheet_z;
	} ofr_in_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] unit_fiber_x;
		logic signed [OUT_BITS-1:0] unit_fiber_y;
		logic signed [OUT_BITS-1:0] unit_fiber_z;
		logic signed [OUT_BITS-1:0] unit_sheet_x;
		logic signed [OUT_BITS-1:0] unit_sheet_y;
		logic signed [OUT_BITS-1:0] unit_sheet_z;
		logic signed [OUT_BITS-1:0] normal_x;
		logic signed [OUT_BITS-1:0] normal_y;
		logic signed [OUT_BITS-1:0] normal_z;
		logic                       degenerate;
	} ofr_out_t;

endpackage

`default_nettype wire

// ===== rtl/orthonormal_frame_from_two_vectors_core.sv =====
// Orthonormal frame core (3-D Gram-Schmidt). Each item carries a fiber vector
// f and a sheet vector s as signed integers; the result is the unit fiber
// f/|f|, the unit sheet (s minus its part along f, normalized) and the normal
// c/|c| with c = f x s, all nine in signed Q1.14, rounded to nearest with ties
// away from zero and exact to the bit. If f is zero or s is parallel to f the
// result has degenerate set and all components zero. One item enters per
// clock while item_ready is high; the path to result_valid is 7 stages of
// cross products, squares and split wide multiplies, then 16 stages of a
// bit-per-stage root recurrence (one per result bit plus one) in nine parallel
// lanes, then a two-entry output buffer. item_ready drops only when that
// buffer holds two results, so a single waiting result does not block input.
`default_nettype none

module orthonormal_frame_from_two_vectors_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire ofr_pkg::ofr_in_t item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output ofr_pkg::ofr_out_t     result
);

	localparam int W      = ofr_pkg::IN_BITS;
	localparam int F      = ofr_pkg::OUT_FRAC_BITS;
	localparam int OW     = ofr_pkg::OUT_BITS;
	localparam int W2     = 2 * W;
	localparam int W3     = 3 * W;
	localparam int W4     = 4 * W;
	localparam int W6     = 6 * W;
	localparam int CW     = W2 + 1;          // signed cross product f x s
	localparam int CW2    = 2 * CW;
	localparam int PW     = W3 + 1;          // signed c x f
	localparam int H      = W3 / 2;          // split of |p| for squaring
	localparam int HW     = W3 - H;
	localparam int LSTEPS = F + 2;
	localparam int NST    = 7 + LSTEPS;
	localparam logic signed [OW-1:0] ONE_Q = OW'(1) << F;

	// ---------------- flow control ----------------
	logic           en;
	logic           push;
	logic           pop;
	logic [1:0]     cnt_q;
	logic [NST-1:0] vld_q;

	// the whole pipeline moves together; it only holds when the buffer is full
	assign en         = (cnt_q != 2'd2);
	assign item_ready = en;
	assign push       = en & vld_q[NST-1];
	assign pop        = result_valid & result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], item_valid};
		end
	end

	// ---------------- datapath registers ----------------
	logic signed [W-1:0]    f_s1 [3];
	logic signed [W-1:0]    s_s1 [3];
	logic signed [W2-1:0]   pa_s2 [3];
	logic signed [W2-1:0]   pb_s2 [3];
	logic        [W2-1:0]   fsq_s2 [3];
	logic signed [W-1:0]    f_s2 [3];
	logic signed [CW-1:0]   c_s3 [3];
	logic        [W2-1:0]   fsq_s3 [3];
	logic signed [W-1:0]    f_s3 [3];
	logic        [W2-1:0]   ff_s3;
	logic        [W4-1:0]   csq_s4 [3];
	logic signed [PW-1:0]   qa_s4 [3];
	logic signed [PW-1:0]   qb_s4 [3];
	logic        [W2-1:0]   fsq_s4 [3];
	logic                   fneg_s4 [3];
	logic                   cneg_s4 [3];
	logic        [W2-1:0]   ff_s4;
	logic                   dg_s4;
	logic signed [PW-1:0]   p_s5 [3];
	logic        [W4-1:0]   csq_s5 [3];
	logic        [W2-1:0]   fsq_s5 [3];
	logic                   fneg_s5 [3];
	logic                   cneg_s5 [3];
	logic        [W4-1:0]   cc_s5;
	logic        [W2-1:0]   ff_s5;
	logic                   dg_s5;
	logic        [2*HW-1:0] hh_s6 [3];
	logic        [HW+H-1:0] hl_s6 [3];
	logic        [2*H-1:0]  ll_s6 [3];
	logic                   pneg_s6 [3];
	logic        [W4-1:0]   csq_s6 [3];
	logic        [W2-1:0]   fsq_s6 [3];
	logic                   fneg_s6 [3];
	logic                   cneg_s6 [3];
	logic        [W4-1:0]   ml_s6;
	logic        [W4-1:0]   mh_s6;
	logic        [W4-1:0]   cc_s6;
	logic        [W2-1:0]   ff_s6;
	logic                   dg_s6;
	logic        [W6-1:0]   psq_s7 [3];
	logic                   pneg_s7 [3];
	logic        [W4-1:0]   csq_s7 [3];
	logic        [W2-1:0]   fsq_s7 [3];
	logic                   fneg_s7 [3];
	logic                   cneg_s7 [3];
	logic        [W6-1:0]   qs_s7;
	logic        [W4-1:0]   cc_s7;
	logic        [W2-1:0]   ff_s7;
	logic                   dg_s7;
	logic                   dg_ls [LSTEPS];

	// lane outputs
	logic [F:0] fmag [3];
	logic [F:0] smag [3];
	logic [F:0] nmag [3];
	logic       fneg_o [3];
	logic       sneg_o [3];
	logic       nneg_o [3];

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1[0] <= item.fiber_x;
			f_s1[1] <= item.fiber_y;
			f_s1[2] <= item.fiber_z;
			s_s1[0] <= item.sheet_x;
			s_s1[1] <= item.sheet_y;
			s_s1[2] <= item.sheet_z;
		end
	end

	for (genvar gi = 0; gi < 3; gi++) begin : g_comp
		localparam int A = (gi + 1) % 3;
		localparam int B = (gi + 2) % 3;
		logic [W3-1:0] pm;

		assign pm = W3'(p_s5[gi][PW-1] ? -p_s5[gi] : p_s5[gi]);

		always_ff @(posedge clk) begin
			if (en) begin
				// stage 2: products for f x s and |f|^2
				pa_s2[gi]   <= W2'(f_s1[A]) * W2'(s_s1[B]);
				pb_s2[gi]   <= W2'(f_s1[B]) * W2'(s_s1[A]);
				fsq_s2[gi]  <= W2'(f_s1[gi]) * W2'(f_s1[gi]);
				f_s2[gi]    <= f_s1[gi];
				// stage 3: c = f x s
				c_s3[gi]    <= CW'(pa_s2[gi]) - CW'(pb_s2[gi]);
				fsq_s3[gi]  <= fsq_s2[gi];
				f_s3[gi]    <= f_s2[gi];
				// stage 4: c^2 and products for p = c x f
				csq_s4[gi]  <= W4'(CW2'(c_s3[gi]) * CW2'(c_s3[gi]));
				qa_s4[gi]   <= PW'(c_s3[A]) * PW'(f_s3[B]);
				qb_s4[gi]   <= PW'(c_s3[B]) * PW'(f_s3[A]);
				fsq_s4[gi]  <= fsq_s3[gi];
				fneg_s4[gi] <= f_s3[gi][W-1];
				cneg_s4[gi] <= c_s3[gi][CW-1];
				// stage 5: p
				p_s5[gi]    <= qa_s4[gi] - qb_s4[gi];
				csq_s5[gi]  <= csq_s4[gi];
				fsq_s5[gi]  <= fsq_s4[gi];
				fneg_s5[gi] <= fneg_s4[gi];
				cneg_s5[gi] <= cneg_s4[gi];
				// stage 6: partial squares of |p|
				hh_s6[gi]   <= (2 * HW)'(pm[W3-1:H]) * (2 * HW)'(pm[W3-1:H]);
				hl_s6[gi]   <= (HW + H)'(pm[W3-1:H]) * (HW + H)'(pm[H-1:0]);
				ll_s6[gi]   <= (2 * H)'(pm[H-1:0]) * (2 * H)'(pm[H-1:0]);
				pneg_s6[gi] <= p_s5[gi][PW-1];
				csq_s6[gi]  <= csq_s5[gi];
				fsq_s6[gi]  <= fsq_s5[gi];
				fneg_s6[gi] <= fneg_s5[gi];
				cneg_s6[gi] <= cneg_s5[gi];
				// stage 7: |p|^2
				psq_s7[gi]  <= (W6'(hh_s6[gi]) << (2 * H)) + (W6'(hl_s6[gi]) << (H + 1))
				               + W6'(ll_s6[gi]);
				pneg_s7[gi] <= pneg_s6[gi];
				csq_s7[gi]  <= csq_s6[gi];
				fsq_s7[gi]  <= fsq_s6[gi];
				fneg_s7[gi] <= fneg_s6[gi];
				cneg_s7[gi] <= cneg_s6[gi];
			end
		end

		ofr_root #(.QW(W2), .RW(W2)) u_fiber (
			.clk     (clk),
			.en      (en),
			.q       (ff_s7),
			.nsq     (fsq_s7[gi]),
			.neg     (fneg_s7[gi]),
			.mag     (fmag[gi]),
			.neg_out (fneg_o[gi])
		);

		ofr_root #(.QW(W6), .RW(W6)) u_sheet (
			.clk     (clk),
			.en      (en),
			.q       (qs_s7),
			.nsq     (psq_s7[gi]),
			.neg     (pneg_s7[gi]),
			.mag     (smag[gi]),
			.neg_out (sneg_o[gi])
		);

		ofr_root #(.QW(W4), .RW(W4)) u_normal (
			.clk     (clk),
			.en      (en),
			.q       (cc_s7),
			.nsq     (csq_s7[gi]),
			.neg     (cneg_s7[gi]),
			.mag     (nmag[gi]),
			.neg_out (nneg_o[gi])
		);
	end

	// shared scalars: |f|^2, |c|^2, |c|^2*|f|^2, degenerate flag
	always_ff @(posedge clk) begin
		if (en) begin
			ff_s3 <= fsq_s2[0] + fsq_s2[1] + fsq_s2[2];
			ff_s4 <= ff_s3;
			dg_s4 <= (ff_s3 == '0) || ((c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0));
			cc_s5 <= csq_s4[0] + csq_s4[1] + csq_s4[2];
			ff_s5 <= ff_s4;
			dg_s5 <= dg_s4;
			// cc is 4W wide: two W2 x W2 halves
			ml_s6 <= W4'(cc_s5[W2-1:0]) * W4'(ff_s5);
			mh_s6 <= W4'(cc_s5[W4-1:W2]) * W4'(ff_s5);
			cc_s6 <= cc_s5;
			ff_s6 <= ff_s5;
			dg_s6 <= dg_s5;
			qs_s7 <= (W6'(mh_s6) << W2) + W6'(ml_s6);
			cc_s7 <= cc_s6;
			ff_s7 <= ff_s6;
			dg_s7 <= dg_s6;
			dg_ls[0] <= dg_s7;
			for (int k = 1; k < LSTEPS; k++) begin
				dg_ls[k] <= dg_ls[k-1];
			end
		end
	end

	// ---------------- result formatting ----------------
	function automatic logic [OW-1:0] fmt(input logic [F:0] m, input logic neg,
	                                      input logic dg);
		logic [OW-1:0] v;
		v = OW'(m);
		if (dg) begin
			return '0;
		end
		return neg ? (OW'(0) - v) : v;
	endfunction

	ofr_pkg::ofr_out_t res_new;
	logic              dg_out;

	assign dg_out = dg_ls[LSTEPS-1];

	always_comb begin
		res_new.unit_fiber_x = fmt(fmag[0], fneg_o[0], dg_out);
		res_new.unit_fiber_y = fmt(fmag[1], fneg_o[1], dg_out);
		res_new.unit_fiber_z = fmt(fmag[2], fneg_o[2], dg_out);
		res_new.unit_sheet_x = fmt(smag[0], sneg_o[0], dg_out);
		res_new.unit_sheet_y = fmt(smag[1], sneg_o[1], dg_out);
		res_new.unit_sheet_z = fmt(smag[2], sneg_o[2], dg_out);
		res_new.normal_x     = fmt(nmag[0], nneg_o[0], dg_out);
		res_new.normal_y     = fmt(nmag[1], nneg_o[1], dg_out);
		res_new.normal_z     = fmt(nmag[2], nneg_o[2], dg_out);
		res_new.degenerate   = dg_out;
	end

	// ---------------- two-entry output buffer ----------------
	ofr_pkg::ofr_out_t e0_q;
	ofr_pkg::ofr_out_t e1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
			e0_q <= res_new;
		end else if (pop) begin
			e0_q <= e1_q;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			e1_q <= res_new;
		end
	end

	assign result_valid = (cnt_q != 2'd0);
	assign result       = e0_q;

	// ---------------- assertions ----------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !item_ready)
		else $error("input accepted while output buffer full");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> result_valid)
		else $error("finished item did not reach the output");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.degenerate) |->
		(result.unit_fiber_x == '0) && (result.unit_fiber_y == '0) &&
		(result.unit_fiber_z == '0) && (result.unit_sheet_x == '0) &&
		(result.unit_sheet_y == '0) && (result.unit_sheet_z == '0) &&
		(result.normal_x == '0) && (result.normal_y == '0) && (result.normal_z == '0))
		else $error("degenerate item with nonzero component");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.degenerate) |->
		(result.unit_sheet_x <= ONE_Q) && (result.unit_sheet_x >= -ONE_Q) &&
		(result.normal_z <= ONE_Q) && (result.normal_z >= -ONE_Q))
		else $error("unit component beyond one");

endmodule

`default_nettype wire

// ===== rtl/ofr_root.sv =====
// ofr_root: pipelined digit recurrence for round(n * 2^F / sqrt(Q)).
// Depends on ofr_pkg (OUT_FRAC_BITS). One result bit per stage.
`default_nettype none

module ofr_root #(
	parameter int QW = 96,
	parameter int RW = 96
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [QW-1:0]                     q,
	input  wire logic [RW-1:0]                     nsq,
	input  wire logic                              neg,
	output logic      [ofr_pkg::OUT_FRAC_BITS:0]   mag,
	output logic                                   neg_out
);

	localparam int FB    = ofr_pkg::OUT_FRAC_BITS;
	localparam int STEPS = FB + 2;
	localparam int RB    = FB + 2;
	localparam int XW    = ((QW > RW) ? QW : RW) + 2 * FB + 5;

	// residual D = n^2*4^(F+1) - Q*r^2, running E = Q*r, root r
	logic [XW-1:0] d_s   [STEPS];
	logic [XW-1:0] e_s   [STEPS];
	logic [QW-1:0] q_s   [STEPS];
	logic [RB-1:0] r_s   [STEPS];
	logic          neg_s [STEPS];
	logic [RB:0]   r_inc;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;
		logic [XW-1:0] d_in;
		logic [XW-1:0] e_in;
		logic [XW-1:0] q_x;
		logic [XW-1:0] cand;
		logic [QW-1:0] q_in;
		logic [RB-1:0] r_in;
		logic          n_in;
		logic          take;

		if (j == 0) begin : g_first
			assign d_in = XW'(nsq) << (2 * FB + 2);
			assign e_in = '0;
			assign q_in = q;
			assign r_in = '0;
			assign n_in = neg;
		end else begin : g_next
			assign d_in = d_s[j-1];
			assign e_in = e_s[j-1];
			assign q_in = q_s[j-1];
			assign r_in = r_s[j-1];
			assign n_in = neg_s[j-1];
		end

		// Q*(r+2^K)^2 - Q*r^2 = 2^(K+1)*E + 4^K*Q
		assign q_x  = XW'(q_in);
		assign cand = (e_in << (K + 1)) + (q_x << (2 * K));
		assign take = (cand <= d_in);

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j]   <= take ? (d_in - cand) : d_in;
				e_s[j]   <= take ? (e_in + (q_x << K)) : e_in;
				r_s[j]   <= take ? (r_in | (RB'(1) << K)) : r_in;
				q_s[j]   <= q_in;
				neg_s[j] <= n_in;
			end
		end
	end

	// r = floor(2n*2^F/sqrt(Q)); nearest with ties up is (r+1)/2
	assign r_inc   = {1'b0, r_s[STEPS-1]} + (RB + 1)'(1);
	assign mag     = r_inc[FB+1:1];
	assign neg_out = neg_s[STEPS-1];

endmodule

`default_nettype wire

// ===== dv/orthonormal_frame_from_two_vectors_core_tb.sv =====
// Testbench for orthonormal_frame_from_two_vectors_core: directed and random frames
// are checked against a bit-exact integer predictor. Depends on rtl/ofr_pkg.sv.
`default_nettype none

module orthonormal_frame_from_two_vectors_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W        = ofr_pkg::IN_BITS;
	localparam int OUT_W       = ofr_pkg::OUT_BITS;
	localparam int FRAC        = ofr_pkg::OUT_FRAC_BITS;
	localparam int LATENCY     = 24;
	localparam int STALL_LIMIT = 4000;  // cycles with no accepted item on either side
	localparam int LONG_HOLD   = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	ofr_pkg::ofr_in_t  item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	ofr_pkg::ofr_out_t result;

	ofr_pkg::ofr_out_t pending_frames[$];
	int       mismatches = 0;
	int       send_idle_pct = 0;   // sender gap probability, percent
	int       recv_stall_pct = 0;  // receiver stall probability, percent
	int       hold_left = 0;       // long receiver hold-off, in cycles
	int       quiet_cycles = 0;

	orthonormal_frame_from_two_vectors_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Signed Q1.F of v / sqrt(q), nearest with ties away from zero. Largest k with
	// (k - 1/2)^2 <= v^2 * 2^(2F) / q, i.e. q * (2k-1)^2 <= v^2 << (2F+2).
	function automatic logic signed [OUT_W-1:0] unit_part(longint v, logic [127:0] q);
		logic [127:0] n;
		logic [127:0] rhs;
		logic [127:0] odd;
		longint lo;
		longint hi;
		longint mid;
		n   = (v < 0) ? -v : v;
		rhs = (n * n) << (2 * FRAC + 2);
		lo  = 0;
		hi  = longint'(1) << FRAC;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			if (q * odd * odd <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (v < 0) ? OUT_W'(-lo) : OUT_W'(lo);
	endfunction

	function automatic ofr_pkg::ofr_out_t frame_predict(ofr_pkg::ofr_in_t x);
		longint f[3];
		longint s[3];
		longint c[3];
		longint p[3];
		logic [127:0] ff;
		logic [127:0] cc;
		ofr_pkg::ofr_out_t r;
		f[0] = x.fiber_x; f[1] = x.fiber_y; f[2] = x.fiber_z;
		s[0] = x.sheet_x; s[1] = x.sheet_y; s[2] = x.sheet_z;
		c[0] = f[1] * s[2] - f[2] * s[1];
		c[1] = f[2] * s[0] - f[0] * s[2];
		c[2] = f[0] * s[1] - f[1] * s[0];
		ff = 128'(f[0] * f[0]) + 128'(f[1] * f[1]) + 128'(f[2] * f[2]);
		cc = 128'(c[0] * c[0]) + 128'(c[1] * c[1]) + 128'(c[2] * c[2]);
		r = '0;
		// zero fiber or sheet parallel to it: no frame
		if (ff == 0 || cc == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		// p = c x f is the sheet with its fiber part removed, scaled by |f|^2
		p[0] = c[1] * f[2] - c[2] * f[1];
		p[1] = c[2] * f[0] - c[0] * f[2];
		p[2] = c[0] * f[1] - c[1] * f[0];
		r.unit_fiber_x = unit_part(f[0], ff);
		r.unit_fiber_y = unit_part(f[1], ff);
		r.unit_fiber_z = unit_part(f[2], ff);
		r.unit_sheet_x = unit_part(p[0], cc * ff);
		r.unit_sheet_y = unit_part(p[1], cc * ff);
		r.unit_sheet_z = unit_part(p[2], cc * ff);
		r.normal_x     = unit_part(c[0], cc);
		r.normal_y     = unit_part(c[1], cc);
		r.normal_z     = unit_part(c[2], cc);
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	// Valid stays high between back-to-back items.
	task automatic send_item(ofr_pkg::ofr_in_t x);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= x;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		pending_frames.push_back(frame_predict(x));
		@(negedge clk);
	endtask

	task automatic stop_sending();
		item_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 6) @(negedge clk);
	endtask

	function automatic ofr_pkg::ofr_in_t make_item(int f[3], int s[3]);
		ofr_pkg::ofr_in_t x;
		x.fiber_x = IN_W'(f[0]); x.fiber_y = IN_W'(f[1]); x.fiber_z = IN_W'(f[2]);
		x.sheet_x = IN_W'(s[0]); x.sheet_y = IN_W'(s[1]); x.sheet_z = IN_W'(s[2]);
		return x;
	endfunction

	function automatic int rand_comp(int kind);
		unique case (kind)
			0: return $signed(16'($urandom));
			1: return $urandom_range(0, 16) - 8;
			2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
			                               : -32768 + $urandom_range(0, 3);
			default: return $urandom_range(0, 600) - 300;
		endcase
	endfunction

	function automatic ofr_pkg::ofr_in_t random_frame();
		int f[3];
		int s[3];
		int kind;
		int shape;
		int k;
		kind  = $urandom_range(0, 3);
		shape = $urandom_range(0, 99);
		for (int i = 0; i < 3; i++) begin
			f[i] = rand_comp(kind);
			s[i] = rand_comp($urandom_range(0, 3));
		end
		if (shape < 6) begin
			f = '{0, 0, 0};
		end else if (shape < 12) begin
			// sheet an exact multiple of the fiber: parallel, antiparallel or zero
			k = $urandom_range(0, 6) - 3;
			for (int i = 0; i < 3; i++) begin
				f[i] = $urandom_range(0, 20000) - 10000;
				s[i] = f[i] * k;
			end
		end else if (shape < 20) begin
			// nearly parallel: tiny normal, sheet dominated by rounding
			for (int i = 0; i < 3; i++)
				s[i] = f[i] / 2 + $urandom_range(0, 2) - 1;
		end else if (shape < 25) begin
			s = '{0, 0, 0};
		end
		return make_item(f, s);
	endfunction

	task automatic test_directed();
		int z[3];
		int mx[3];
		int mn[3];
		z  = '{0, 0, 0};
		mx = '{32767, 32767, 32767};
		mn = '{-32768, -32768, -32768};
		send_item(make_item(z, '{1, 2, 3}));
		send_item(make_item(z, z));
		send_item(make_item('{1, 0, 0}, '{0, 1, 0}));
		send_item(make_item('{0, 0, 1}, '{1, 0, 0}));
		send_item(make_item('{0, -1, 0}, '{0, 0, -1}));
		send_item(make_item(mx, mx));
		send_item(make_item(mn, mn));
		send_item(make_item(mx, mn));
		send_item(make_item('{32767, 0, 0}, '{-32768, -32768, 32767}));
		send_item(make_item('{-32768, 32767, 0}, '{32767, -32768, -32768}));
		send_item(make_item('{-32768, 0, 0}, '{0, 0, -32768}));
		send_item(make_item('{3, 4, 0}, '{6, 8, 0}));
		send_item(make_item('{3, 4, 0}, '{-3, -4, 0}));
		send_item(make_item('{1, 1, 1}, '{1, 1, 2}));
		send_item(make_item('{1, 2, 2}, z));
		send_item(make_item('{32767, 32767, -32768}, '{1, 0, 0}));
		send_item(make_item('{1, 1, 0}, '{1, 0, 0}));
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random(int n, int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_item(random_frame());
		stop_sending();
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering, so the pipeline and
	// output buffer fill and item_ready drops.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = LONG_HOLD;
		for (int i = 0; i < 80; i++)
			send_item(random_frame());
		stop_sending();
		wait_drained();
	endtask

	// receiver: random stalls, plus the long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// result checker, sampled on the rising edge
	always @(posedge clk) begin
		ofr_pkg::ofr_out_t want;
		if (result_valid && result_ready) begin
			if (pending_frames.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
			end else begin
				want = pending_frames.pop_front();
				check_field("unit_fiber_x", want.unit_fiber_x, result.unit_fiber_x);
				check_field("unit_fiber_y", want.unit_fiber_y, result.unit_fiber_y);
				check_field("unit_fiber_z", want.unit_fiber_z, result.unit_fiber_z);
				check_field("unit_sheet_x", want.unit_sheet_x, result.unit_sheet_x);
				check_field("unit_sheet_y", want.unit_sheet_y, result.unit_sheet_y);
				check_field("unit_sheet_z", want.unit_sheet_z, result.unit_sheet_z);
				check_field("normal_x", want.normal_x, result.normal_x);
				check_field("normal_y", want.normal_y, result.normal_y);
				check_field("normal_z", want.normal_z, result.normal_z);
				check_field("degenerate", want.degenerate, result.degenerate);
			end
		end
	end

	// watchdog: too long with nothing accepted on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(450, 0, 0);
		test_random(450, 88, 0);
		test_backpressure();
		test_random(450, 0, 88);
		test_random(450, 36, 36);
		if (mismatches == 0 && pending_frames.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
